// ===== rtl/core/icymfe_pkg.sv =====
// ----------------------------------------------------------------------------
// icymfe_pkg
// Types and constants shared by the metadata field extractor modules.
// ----------------------------------------------------------------------------
package icymfe_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_EQUALS  = 2'd1,
    ST_NOT_QUOTED = 2'd2
  } status_e;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [3:0] TITLE_LEN = 4'd11;
  localparam logic [3:0] URL_LEN   = 4'd9;

  // result slots of one word, in output order
  localparam int unsigned SLOT_APOS  = 0;
  localparam int unsigned SLOT_BYTE  = 1;
  localparam int unsigned SLOT_TAIL  = 2;
  localparam int unsigned SLOT_END   = 3;
  localparam int unsigned SLOT_STAT  = 4;
  localparam int unsigned NUM_SLOTS  = 5;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic                 field;
    logic [7:0]           data;
    status_e              status;
  } bundle_t;

  function automatic logic [7:0] title_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h53; // S
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6d; // m
      4'd6:    ch = 8'h54; // T
      4'd7:    ch = 8'h69; // i
      4'd8:    ch = 8'h74; // t
      4'd9:    ch = 8'h6c; // l
      4'd10:   ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] url_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h53; // S
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6d; // m
      4'd6:    ch = 8'h55; // U
      4'd7:    ch = 8'h52; // R
      4'd8:    ch = 8'h4c; // L
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/icy_metadata_field_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// icy_metadata_field_extractor_unit
// Splits ICY metadata blocks into StreamTitle / StreamURL value results.
// ----------------------------------------------------------------------------
// One metadata byte is taken per cycle while full is low. The classifier
// updates its flags in that cycle and queues one word naming the one to
// four results the byte causes, if any; the sequencer drains the queue at
// one result per cycle while the output is empty or popped, so bytes keep
// flowing at one per cycle as long as they average at most one result
// each; full rises when QueueDepth words wait. An output register holds
// each result. Value bytes lag the input by one byte; a status result
// closes each block, and on a nonzero status the block's values are to be dropped.
module icy_metadata_field_extractor_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte_i,
  input  logic                block_end_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          item_kind_o,
  output logic                field_id_o,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          status_o,
  output logic                last_result_o
);
  import icymfe_pkg::*;

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle, head;
  logic    q_full, q_empty, q_pop;
  kind_e   kind;
  status_e status;

  assign full   = q_full;
  assign accept = push && !q_full;

  icymfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .block_end_i    (block_end_i),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  icymfe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (bundle_valid),
    .wr_data_i (bundle),
    .rd_en_i   (q_pop),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  icymfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_empty_i  (q_empty),
    .head_pop_o    (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .item_kind_o   (kind),
    .field_id_o    (field_id_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status),
    .last_result_o (last_result_o)
  );

  assign item_kind_o = kind;
  assign status_o    = status;

`ifndef NO_ASSERTIONS
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind == KIND_STATUS) |-> (last_result_o && !field_id_o))
    else $error("status result not last or carries a field");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind == KIND_END) |-> (out_byte_o == 8'h00 && status == ST_OK))
    else $error("end marker carries data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(item_kind_o) && $stable(out_byte_o)))
    else $error("result changed while stalled");
`endif

endmodule

// ===== rtl/core/icymfe_front.sv =====
// ----------------------------------------------------------------------------
// icymfe_front
// Byte classifier: quote tracking, key match, value hold-back and status.
// Emits a word for each byte that causes results, listing those results.
// ----------------------------------------------------------------------------
module icymfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                block_end_i,
  output logic                bundle_valid_o,
  output icymfe_pkg::bundle_t bundle_o
);
  import icymfe_pkg::*;

  logic       quote_q, quote_d;
  logic       qmc_q, qmc_d;
  logic       eq_q, eq_d;
  logic [1:0] bae_q, bae_d;
  logic [3:0] kp_q, kp_d;
  logic [3:0] kf_q, kf_d;
  logic       hv_q, hv_d;
  logic [7:0] hb_q, hb_d;
  logic       pa_q, pa_d;
  status_e    err_q, err_d;
  bundle_t    bundle;

  always_comb begin
    logic [7:0] c;
    logic       qo, qmc, eq, hv, pa, outside, is_eq, is_semi, fin;
    logic [1:0] bae;
    logic [3:0] kp, kf;
    logic [7:0] hb, vbyte;
    status_e    err;
    logic [NUM_SLOTS-1:0] slots;

    c = in_byte_i;
    qo = quote_q; qmc = qmc_q; eq = eq_q; bae = bae_q; kp = kp_q; kf = kf_q;
    hv = hv_q; hb = hb_q; pa = pa_q; err = err_q;
    slots = '0; vbyte = 8'h00; fin = 1'b0;
    outside = 1'b0; is_eq = 1'b0; is_semi = 1'b0;

    if (err_q == ST_OK) begin
      outside = !quote_q;
      if (quote_q) begin
        if (qmc_q) begin
          qmc = 1'b0;
          if (c != CH_QUOTE) begin
            qo = 1'b0;
            outside = 1'b1;
          end
        end else if (c == CH_QUOTE) begin
          qmc = 1'b1;
        end
      end
      if (outside) begin
        if (c == CH_EQ && !eq_q) begin
          is_eq = 1'b1;
        end else if (c == CH_QUOTE) begin
          qo = 1'b1;
        end else if (c == CH_SEMI) begin
          is_semi = 1'b1;
        end
      end
      if (!is_semi) begin
        if (eq_q) begin
          if (bae_q == 2'd0) begin
            if (c != CH_QUOTE) err = ST_NOT_QUOTED;
          end else if (kf_q[1:0] != 2'b00) begin
            if (hv_q) begin
              if (hb_q == CH_QUOTE) begin
                if (pa_q) begin
                  slots[SLOT_BYTE] = 1'b1;
                  vbyte = CH_QUOTE;
                  pa = 1'b0;
                end else begin
                  pa = 1'b1;
                end
              end else begin
                slots[SLOT_APOS] = pa_q;
                slots[SLOT_BYTE] = 1'b1;
                vbyte = hb_q;
                pa = 1'b0;
              end
            end
            hb = c;
            hv = 1'b1;
          end
          if (bae_q != 2'd3) bae = bae_q + 2'd1;
        end else if (is_eq) begin
          eq = 1'b1;
          if (kp_q != TITLE_LEN) kf[0] = 1'b0;
          if (kp_q != URL_LEN) kf[1] = 1'b0;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          if (kf_q[2]) kf[3] = 1'b1;
        end else begin
          if (kf_q[3]) kf[1:0] = 2'b00;
          kf[2] = 1'b1;
          if (!(kp_q < TITLE_LEN && c == title_char(kp_q))) kf[0] = 1'b0;
          if (!(kp_q < URL_LEN && c == url_char(kp_q))) kf[1] = 1'b0;
          if (kp_q != 4'd15) kp = kp_q + 4'd1;
        end
      end
      fin = is_semi || (block_end_i && err == ST_OK);
      if (fin) begin
        if (!eq) begin
          err = ST_NO_EQUALS;
        end else if (bae < 2'd2) begin
          err = ST_NOT_QUOTED;
        end else if (kf[1:0] != 2'b00) begin
          slots[SLOT_TAIL] = pa;
          slots[SLOT_END]  = 1'b1;
        end
      end
    end
    if (block_end_i) slots[SLOT_STAT] = 1'b1;

    bundle.slots  = slots;
    bundle.field  = kf[1];
    bundle.data   = vbyte;
    bundle.status = err;

    if (block_end_i || fin) begin
      quote_d = 1'b0; qmc_d = 1'b0; eq_d = 1'b0; bae_d = 2'd0; kp_d = 4'd0;
      kf_d = 4'b0011; hv_d = 1'b0; hb_d = 8'h00; pa_d = 1'b0;
      err_d = block_end_i ? ST_OK : err;
    end else begin
      quote_d = qo; qmc_d = qmc; eq_d = eq; bae_d = bae; kp_d = kp;
      kf_d = kf; hv_d = hv; hb_d = hb; pa_d = pa; err_d = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= 1'b0;
      qmc_q   <= 1'b0;
      eq_q    <= 1'b0;
      bae_q   <= 2'd0;
      kp_q    <= 4'd0;
      kf_q    <= 4'b0011;
      hv_q    <= 1'b0;
      hb_q    <= 8'h00;
      pa_q    <= 1'b0;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      quote_q <= quote_d;
      qmc_q   <= qmc_d;
      eq_q    <= eq_d;
      bae_q   <= bae_d;
      kp_q    <= kp_d;
      kf_q    <= kf_d;
      hv_q    <= hv_d;
      hb_q    <= hb_d;
      pa_q    <= pa_d;
      err_q   <= err_d;
    end
  end

  assign bundle_valid_o = accept_i && (bundle.slots != '0);
  assign bundle_o       = bundle;

endmodule

// ===== rtl/core/icymfe_fifo.sv =====
// ----------------------------------------------------------------------------
// icymfe_fifo
// Short word queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module icymfe_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  icymfe_pkg::bundle_t wr_data_i,
  input  logic                rd_en_i,
  output icymfe_pkg::bundle_t rd_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import icymfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/icymfe_back.sv =====
// ----------------------------------------------------------------------------
// icymfe_back
// Result sequencer: walks the slots of the head word into the output register,
// one result per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module icymfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  icymfe_pkg::bundle_t head_i,
  input  logic                head_empty_i,
  output logic                head_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output icymfe_pkg::kind_e   item_kind_o,
  output logic                field_id_o,
  output logic [7:0]          out_byte_o,
  output icymfe_pkg::status_e status_o,
  output logic                last_result_o
);
  import icymfe_pkg::*;

  logic [NUM_SLOTS-1:0] done_q, rem, pick, left;
  logic                 out_valid_q;
  kind_e                kind_q, kind_d;
  logic                 field_q, field_d;
  logic [7:0]           byte_q, byte_d;
  status_e              status_q, status_d;
  logic                 last_q;
  logic                 load;

  assign rem  = head_i.slots & ~done_q;
  assign pick = rem & (~rem + NUM_SLOTS'(1));
  assign left = rem & ~pick;
  assign load = (!out_valid_q || pop_i) && !head_empty_i;
  assign head_pop_o = load && (left == '0);

  always_comb begin
    kind_d   = KIND_BYTE;
    field_d  = head_i.field;
    byte_d   = 8'h00;
    status_d = ST_OK;
    if (pick[SLOT_APOS] || pick[SLOT_TAIL]) begin
      byte_d = CH_QUOTE;
    end else if (pick[SLOT_BYTE]) begin
      byte_d = head_i.data;
    end else if (pick[SLOT_END]) begin
      kind_d = KIND_END;
    end else begin
      kind_d   = KIND_STATUS;
      field_d  = 1'b0;
      status_d = head_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        done_q      <= (left == '0) ? '0 : (done_q | pick);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      field_q  <= field_d;
      byte_q   <= byte_d;
      status_q <= status_d;
      last_q   <= (left == '0);
    end
  end

  assign empty_o       = !out_valid_q;
  assign item_kind_o   = kind_q;
  assign field_id_o    = field_q;
  assign out_byte_o    = byte_q;
  assign status_o      = status_q;
  assign last_result_o = last_q;

endmodule
